### rtl/core/nfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfe_pkg;

  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int NAME_W  = 24;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [NAME_W-1:0] NAME_MAX = 24'h4D4158;
  localparam logic [NAME_W-1:0] NAME_SUM = 24'h53554D;
  localparam logic [NAME_W-1:0] NAME_DIF = 24'h444946;
  localparam logic [NAME_W-1:0] NAME_MIN = 24'h4D494E;

  typedef enum logic [2:0] {
    OP_MAX = 3'd0,
    OP_SUM = 3'd1,
    OP_DIF = 3'd2,
    OP_MIN = 3'd3,
    OP_GCD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_GCD,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] first;
    logic [VALUE_W-1:0] second;
    logic [1:0]         vbits;
  } frame_t;

endpackage

`default_nettype wire

### rtl/core/nested_function_expression_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// A comma with a frame open reads the top frame, then in S_TOP stores the literal as its first
// operand if none is set; a closing parenthesis with a frame open goes through S_TOP, S_GCD (the
// binary GCD unit, for GCD only) and S_RESULT; an outermost close also holds while the previous
// result waits under out_stall. Other characters and stray separators are taken in S_IDLE alone;
// frame updates are read-modify-writes. One character per transfer, the next once that completes.
// Reset: clears sequencer, depth, literal, recent characters, error flag and output valid.
module nested_function_expression_evaluator #(
  parameter int MAX_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [nfe_pkg::CHAR_W-1:0]         char_in,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [nfe_pkg::VALUE_W-1:0]      value,
  output logic                                    status
);
  import nfe_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  state_t              state, state_next;
  logic [DW-1:0]       depth;
  logic [DW-1:0]       depth_m1, depth_m2;
  logic [VALUE_W-1:0]  lit;
  logic [NAME_W-1:0]   recent;
  logic                err;
  logic                pend_close;
  logic [VALUE_W-1:0]  res;
  logic [VALUE_W-1:0]  ga, gb;
  logic [5:0]          gk;

  frame_t              mem [MAX_DEPTH];
  frame_t              rd_data;
  frame_t              wr_data;
  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;

  logic                accept, is_digit, is_sep, gcd_done, is_gcd;
  logic [CHAR_W-1:0]   dig;
  op_t                 op_new;
  logic [VALUE_W-1:0]  opa, opb, alu, mag_a, mag_b, lit_next;

  assign accept   = in_valid && !in_stall;
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_sep   = (char_in == CH_COMMA) || (char_in == CH_CLOSE);
  assign dig      = char_in - CH_ZERO;
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign gcd_done = (ga == '0) || (gb == '0);
  assign lit_next = (lit << 3) + (lit << 1) + VALUE_W'(dig[3:0]);

  always_comb begin
    case (recent)
      NAME_MAX: op_new = OP_MAX;
      NAME_SUM: op_new = OP_SUM;
      NAME_DIF: op_new = OP_DIF;
      NAME_MIN: op_new = OP_MIN;
      default:  op_new = OP_GCD;
    endcase
  end

  assign opa   = rd_data.vbits[0] ? rd_data.first : '0;
  assign opb   = rd_data.vbits[1] ? rd_data.second : lit;
  assign mag_a = opa[VALUE_W-1] ? (~opa + VALUE_W'(1)) : opa;
  assign mag_b = opb[VALUE_W-1] ? (~opb + VALUE_W'(1)) : opb;

  always_comb begin
    is_gcd = 1'b0;
    case (rd_data.op)
      OP_MAX:  alu = ($signed(opa) < $signed(opb)) ? opb : opa;
      OP_SUM:  alu = opa + opb;
      OP_DIF:  alu = opa - opb;
      OP_MIN:  alu = ($signed(opb) < $signed(opa)) ? opb : opa;
      default: begin
        alu    = '0;
        is_gcd = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_sep && depth != '0) state_next = S_TOP;
      end
      S_TOP: begin
        if (!pend_close) state_next = S_IDLE;
        else if (is_gcd) state_next = S_GCD;
        else state_next = S_RESULT;
      end
      S_GCD: begin
        if (gcd_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (depth != '0 || !out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    rd_en    = 1'b0;
    rd_addr  = depth_m1[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = depth_m1[AW-1:0];
    wr_data  = rd_data;
    case (state)
      S_IDLE: begin
        if (accept && char_in == CH_OPEN && depth < DW'(MAX_DEPTH)) begin
          wr_en   = 1'b1;
          wr_addr = depth[AW-1:0];
          wr_data = '{op: op_new, first: '0, second: '0, vbits: 2'b00};
        end
        rd_en = accept && is_sep && depth != '0;
      end
      S_TOP: begin
        if (!pend_close && !rd_data.vbits[0]) begin
          wr_en         = 1'b1;
          wr_data.first = lit;
          wr_data.vbits = rd_data.vbits | 2'b01;
        end
        if (pend_close && depth != DW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = depth_m2[AW-1:0];
        end
      end
      S_RESULT: begin
        if (depth != '0) begin
          wr_en = 1'b1;
          if (!rd_data.vbits[0]) begin
            wr_data.first = res;
            wr_data.vbits = rd_data.vbits | 2'b01;
          end else begin
            wr_data.second = res;
            wr_data.vbits  = rd_data.vbits | 2'b10;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      lit       <= '0;
      recent    <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_RESULT && depth == '0 && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            recent <= {recent[NAME_W-CHAR_W-1:0], char_in};
            if (char_in == CH_OPEN) begin
              lit <= '0;
              if (depth < DW'(MAX_DEPTH)) depth <= depth + DW'(1);
              else err <= 1'b1;
            end else if (is_digit) begin
              lit <= lit_next;
            end
          end
        end
        S_TOP: begin
          if (pend_close) begin
            depth <= depth_m1;
            lit   <= '0;
          end else if (!rd_data.vbits[0]) begin
            lit <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) pend_close <= (char_in == CH_CLOSE);
    if (state == S_RESULT && depth == '0 && (!out_valid || !out_stall)) begin
      value  <= res;
      status <= err;
    end
    case (state)
      S_TOP: begin
        res <= alu;
        ga  <= mag_a;
        gb  <= mag_b;
        gk  <= '0;
      end
      S_GCD: begin
        if (gcd_done) begin
          res <= (ga | gb) << gk;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + 6'd1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= (ga - gb) >> 1;
        end else begin
          gb <= (gb - ga) >> 1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
